[src/queued_line_lock_table_top_defines.svh]
// ----------------------------------------------------------------------------
// queued line lock table assertion macros
// shared property wrappers for the lock table checks
// ----------------------------------------------------------------------------
`ifndef QUEUED_LINE_LOCK_TABLE_TOP_DEFINES_SVH
`define QUEUED_LINE_LOCK_TABLE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define QLLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define QLLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/qllt_pkg.sv]
// ----------------------------------------------------------------------------
// qllt_pkg
// types and constants shared by the line lock table modules
// ----------------------------------------------------------------------------
package qllt_pkg;

  localparam int ADDR_W   = 32;
  localparam int THREAD_W = 4;
  localparam int POS_W    = 4;
  localparam logic [POS_W-1:0] POS_MAX = 4'd15;

  // request function codes
  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_LOCK_ENABLE = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FINISH = 5'b10000
  } qllt_state_t;

  typedef struct packed {
    logic load;
    logic read_self;
    logic decide;
    logic scan;
    logic finish;
  } qllt_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } qllt_status_t;

endpackage

[src/qllt_ram.sv]
// ----------------------------------------------------------------------------
// qllt_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module qllt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/qllt_ctrl.sv]
// ----------------------------------------------------------------------------
// qllt_ctrl
// sequencer for one lock request: read own entry, decide, scan, finish
// ----------------------------------------------------------------------------
`include "queued_line_lock_table_top_defines.svh"

module qllt_ctrl
  import qllt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  qllt_status_t status,
  output qllt_cmd_t    cmd,
  output logic         busy
);

  qllt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = status.need_scan ? ST_SCAN : ST_FINISH;
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load      = (state == ST_IDLE) && start;
    cmd.read_self = (state == ST_READ);
    cmd.decide    = (state == ST_CHECK);
    cmd.scan      = (state == ST_SCAN);
    cmd.finish    = (state == ST_FINISH);
  end

  assign busy = (state != ST_IDLE);

  `QLLT_ASSERT_NEXT(a_accept_reads, (state == ST_IDLE) && start, state == ST_READ, "accept did not start read")
  `QLLT_ASSERT_NEXT(a_finish_idle, state == ST_FINISH, state == ST_IDLE, "finish not followed by idle")
  `QLLT_ASSERT_NEXT(a_no_scan_skip, (state == ST_CHECK) && !status.need_scan, state == ST_FINISH, "check without scan must finish")
  `QLLT_ASSERT_NOW(a_done_idle_scan, status.scan_done, state == ST_SCAN || state == ST_FINISH || state == ST_IDLE, "scan done outside scan")

endmodule

[src/qllt_dpath.sv]
// ----------------------------------------------------------------------------
// qllt_dpath
// lock table storage, own-entry check and sequential scan over all entries
// ----------------------------------------------------------------------------
module qllt_dpath
  import qllt_pkg::*;
#(
  parameter int THREADS          = 16,
  parameter int LINE_OFFSET_BITS = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  qllt_cmd_t           cmd,
  output qllt_status_t        status,
  input  logic                lock_enable,
  input  logic                func,
  input  logic [THREAD_W-1:0] thread,
  input  logic [ADDR_W-1:0]   address,
  output logic                granted,
  output logic                error,
  output logic [POS_W-1:0]    position
);

  localparam int TW     = $clog2(THREADS);
  localparam int LINE_W = ADDR_W - LINE_OFFSET_BITS;
  localparam int WORD_W = LINE_W + POS_W;
  localparam logic [TW:0]   CNT_END  = (TW+1)'(THREADS);
  localparam logic [TW-1:0] IDX_LAST = TW'(THREADS - 1);

  // request registers
  logic                func_q;
  logic [THREAD_W-1:0] thread_q;
  logic [LINE_W-1:0]   line_q;
  logic                alloc_q;

  // scan state
  logic [TW:0]         scan_cnt;
  logic                proc_q;
  logic [TW-1:0]       proc_idx;
  logic                held_q;
  logic [POS_W-1:0]    maxpos_q;

  logic [THREADS-1:0]  valid_q;

  // ram
  logic                ram_we;
  logic [TW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [TW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [TW-1:0]       t_idx;
  logic                in_range;
  logic [LINE_W-1:0]   rd_line;
  logic [POS_W-1:0]    rd_pos;
  logic                self_valid;
  logic                self_hit;
  logic                hit;
  logic                held_n;
  logic [POS_W-1:0]    maxpos_n;
  logic [POS_W-1:0]    new_pos;

  assign t_idx    = TW'(thread_q);
  assign in_range = (32'(thread_q) < THREADS);
  assign rd_line  = ram_rdata[WORD_W-1:POS_W];
  assign rd_pos   = ram_rdata[POS_W-1:0];

  assign self_valid = valid_q[t_idx];
  assign self_hit   = (rd_line == line_q);

  // scan element compare, one entry per cycle
  assign hit      = proc_q && valid_q[proc_idx] && (rd_line == line_q);
  assign held_n   = held_q | hit;
  assign maxpos_n = (hit && (rd_pos > maxpos_q)) ? rd_pos : maxpos_q;
  assign new_pos  = !held_n ? '0 :
                    (maxpos_n == POS_MAX) ? POS_MAX : maxpos_n + POS_W'(1);

  always_comb begin
    status.need_scan = lock_enable && in_range &&
                       ((self_valid && self_hit && (func_q == FUNC_RELEASE)) ||
                        (!self_valid && (func_q == FUNC_ACQUIRE)));
    status.scan_done = cmd.scan && proc_q && (proc_idx == IDX_LAST);
  end

  assign ram_raddr = cmd.read_self ? t_idx : scan_cnt[TW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_idx;
    ram_wdata = {line_q, rd_pos - POS_W'(1)};
    if (cmd.scan && !alloc_q && hit && (rd_pos != '0)) begin
      ram_we = 1'b1;
    end else if (cmd.finish && alloc_q) begin
      ram_we    = 1'b1;
      ram_waddr = t_idx;
      ram_wdata = {line_q, position};
    end
  end

  qllt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(THREADS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      thread_q <= thread;
      line_q   <= address[ADDR_W-1:LINE_OFFSET_BITS];
    end
  end

  // valid bits and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q  <= '0;
      scan_cnt <= '0;
      proc_q   <= 1'b0;
      alloc_q  <= 1'b0;
      held_q   <= 1'b0;
    end else begin
      if (cmd.decide) begin
        scan_cnt <= '0;
        proc_q   <= 1'b0;
        held_q   <= 1'b0;
        alloc_q  <= status.need_scan && !self_valid;
        // release clears own entry before the waiters move up
        if (status.need_scan && self_valid) begin
          valid_q[t_idx] <= 1'b0;
        end
      end
      if (cmd.scan) begin
        held_q <= held_n;
        if (scan_cnt < CNT_END) begin
          scan_cnt <= scan_cnt + (TW+1)'(1);
          proc_q   <= 1'b1;
        end else begin
          proc_q <= 1'b0;
        end
      end
      if (cmd.finish && alloc_q) begin
        valid_q[t_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      maxpos_q <= '0;
    end else if (cmd.scan) begin
      maxpos_q <= maxpos_n;
    end
    if (cmd.scan) begin
      proc_idx <= scan_cnt[TW-1:0];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (!lock_enable) begin
        granted  <= (func_q == FUNC_ACQUIRE);
        error    <= 1'b0;
        position <= '0;
      end else if (!in_range) begin
        granted  <= 1'b0;
        error    <= 1'b1;
        position <= '0;
      end else if (self_valid && !self_hit) begin
        granted  <= 1'b0;
        error    <= 1'b1;
        position <= rd_pos;
      end else if (self_valid && (func_q == FUNC_ACQUIRE)) begin
        granted  <= (rd_pos == '0);
        error    <= 1'b0;
        position <= rd_pos;
      end else begin
        granted  <= 1'b0;
        error    <= 1'b0;
        position <= '0;
      end
    end else if (status.scan_done && alloc_q) begin
      granted  <= !held_n;
      error    <= 1'b0;
      position <= new_pos;
    end
  end

endmodule

[src/queued_line_lock_table_top.sv]
// flow: an accepted start passes through read and check, and done strobes in finish when no
// scan is needed; a new acquire or a matching release also scans between check and finish
// a new request is taken only in idle, so busy covers the whole request, including the
// one-entry-a-cycle scan through the single read port of the entry ram
// reset: rst clears all entry valid bits at once and sets lock_enable to 1
// results cannot be stalled: done is high for exactly one cycle per request
// ----------------------------------------------------------------------------
// queued_line_lock_table_top
// per-thread cache line lock table with fifo queue positions
// ----------------------------------------------------------------------------
module queued_line_lock_table_top
  import qllt_pkg::*;
#(
  parameter int THREADS          = 16,
  parameter int LINE_OFFSET_BITS = 5
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic [THREAD_W-1:0] thread,
  input  logic [ADDR_W-1:0]   address,
  // result channel
  output logic                done,
  output logic                granted,
  output logic                error,
  output logic [POS_W-1:0]    position,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  qllt_cmd_t    cmd;
  qllt_status_t status;
  logic         lock_enable;
  logic         cfg_wr;

  // single config register; word index is paddr[2], anything else reads zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_enable <= 1'b1;
    end else if (cfg_wr && (paddr[2] == REG_LOCK_ENABLE)) begin
      lock_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LOCK_ENABLE) begin
      prdata = {31'b0, lock_enable};
    end
  end

  // controller: steps read, check, scan and finish for each request
  qllt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: entry ram, valid bits, scan compare and result registers
  qllt_dpath #(
    .THREADS         (THREADS),
    .LINE_OFFSET_BITS(LINE_OFFSET_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .lock_enable(lock_enable),
    .func       (func),
    .thread     (thread),
    .address    (address),
    .granted    (granted),
    .error      (error),
    .position   (position)
  );

  // result registers are settled by the finish cycle
  assign done = cmd.finish;

endmodule
